// File: rtl/core/swg_pkg.sv
// Shared constants for the swipe gesture detector: event kinds, gesture codes,
// register indexes, reset values and default sizes. No dependencies.
package swg_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int COORD_BITS_DEF = 12;

    // Event kinds on the func field.
    localparam logic [1:0] FUNC_DOWN   = 2'd0;
    localparam logic [1:0] FUNC_MOTION = 2'd1;
    localparam logic [1:0] FUNC_UP     = 2'd2;

    // Gesture codes.
    localparam logic [2:0] GEST_NONE  = 3'd0;
    localparam logic [2:0] GEST_RIGHT = 3'd1;
    localparam logic [2:0] GEST_LEFT  = 3'd2;
    localparam logic [2:0] GEST_UP    = 3'd3;
    localparam logic [2:0] GEST_DOWN  = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic       CFG_WINDOW    = 1'b0;
    localparam logic       CFG_MIN_DIST  = 1'b1;
    localparam logic [15:0] WINDOW_RESET = 16'd500;
    localparam logic [11:0] MIN_RESET    = 12'd50;

endpackage

// File: rtl/core/swipe_gesture_detector.sv
// Swipe gesture detector: point ring, window pruning and swipe search; needs swg_pkg, swg_isqrt.
// Up and unused events go straight to the result; down first appends its point. Motion
// drops the oldest points while older than the window, appends, then for each point searched
// squares and roots the segment and the chord on the one-bit-per-cycle square-root unit.
// One request at a time: in_ready is low from acceptance until the result is taken.
// Reset (rst_n, asynchronous, active low) empties the store and restores the registers.
module swipe_gesture_detector import swg_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [11:0] x_position,
    input  logic [11:0] y_position,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  gesture_code
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int QW   = CW + 5;
    localparam int PW   = QW + AW + 1;
    localparam int CMPW = PW + 4;
    localparam int EW   = 2 * CW + 32;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_PRUNE_RD   = 13'b0000000000010,
        ST_PRUNE_CHK  = 13'b0000000000100,
        ST_APPEND     = 13'b0000000001000,
        ST_SRCH_RD    = 13'b0000000010000,
        ST_SEG_MUL    = 13'b0000000100000,
        ST_SEG_START  = 13'b0000001000000,
        ST_SEG_WAIT   = 13'b0000010000000,
        ST_DIST_MUL   = 13'b0000100000000,
        ST_DIST_START = 13'b0001000000000,
        ST_DIST_WAIT  = 13'b0010000000000,
        ST_TEST       = 13'b0100000000000,
        ST_OUT        = 13'b1000000000000
    } state_t;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
            s = s - DEPTH_W;
        return s[AW-1:0];
    endfunction

    state_t          state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [AW-1:0]   oldest_reg, oldest_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [2:0]      code_reg, code_next;
    logic [15:0]     window_reg;
    logic [11:0]     min_reg;

    logic [CW-1:0]   x_reg, x_next, y_reg, y_next;
    logic [31:0]     t_reg, t_next;
    logic [CW-1:0]   prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [CW-1:0]   cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [2*CW:0]   sq_reg, sq_next;
    logic [PW-1:0]   path_reg, path_next;
    logic [QW-1:0]   dist_reg, dist_next;

    // Point ring memory.
    logic [EW-1:0] ring [DEPTH];
    logic [EW-1:0] rd_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [CW-1:0] rd_x, rd_y;
    logic [31:0]   rd_t;

    // Shared square-root unit.
    logic            sqrt_start, sqrt_done;
    logic [QW-1:0]   sqrt_root;
    logic [2*QW-1:0] radicand;

    // Squaring datapath and test terms.
    logic [CW-1:0]   a_x, a_y, b_x, b_y, adx, ady;
    logic [2*CW-1:0] sqx, sqy;
    logic [2*CW:0]   sq_sum;
    logic            full;
    logic [AW-1:0]   eff_old, eff_cnt;
    logic [31:0]     age;
    logic [PW-1:0]   d_ext, gap;
    logic [CMPW-1:0] gap10, d_cmp, min_q4;
    logic [CW-1:0]   tdx, tdy;

    assign rd_x = rd_reg[CW-1:0];
    assign rd_y = rd_reg[2*CW-1:CW];
    assign rd_t = rd_reg[EW-1:2*CW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring[wr_addr] <= {t_reg, y_reg, x_reg};
        rd_reg <= ring[rd_addr];
    end

    assign radicand = (2 * QW)'({sq_reg, 8'b0});

    swg_isqrt #(
        .QW (QW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Squared distance: a segment (read point to previous) or a chord (current to newest).
    always_comb
    begin
        if (state_reg == ST_DIST_MUL)
        begin
            a_x = cur_x_reg;
            a_y = cur_y_reg;
            b_x = x_reg;
            b_y = y_reg;
        end
        else
        begin
            a_x = rd_x;
            a_y = rd_y;
            b_x = prev_x_reg;
            b_y = prev_y_reg;
        end
        adx    = (a_x >= b_x) ? a_x - b_x : b_x - a_x;
        ady    = (a_y >= b_y) ? a_y - b_y : b_y - a_y;
        sqx    = {{CW{1'b0}}, adx} * {{CW{1'b0}}, adx};
        sqy    = {{CW{1'b0}}, ady} * {{CW{1'b0}}, ady};
        sq_sum = {1'b0, sqx} + {1'b0, sqy};
    end

    // Append bookkeeping, age and swipe test terms.
    always_comb
    begin
        full    = (count_reg == CNTW'(DEPTH));
        eff_old = full ? wrap_add(oldest_reg, AW'(1)) : oldest_reg;
        eff_cnt = full ? AW'(DEPTH - 1) : count_reg[AW-1:0];
        age     = t_reg - rd_t;
        d_ext   = PW'(dist_reg);
        gap     = (path_reg > d_ext) ? path_reg - d_ext : d_ext - path_reg;
        gap10   = CMPW'({gap, 3'b0}) + CMPW'({gap, 1'b0});
        d_cmp   = CMPW'(dist_reg);
        min_q4  = CMPW'({min_reg, 4'b0});
        tdx     = (x_reg >= cur_x_reg) ? x_reg - cur_x_reg : cur_x_reg - x_reg;
        tdy     = (y_reg >= cur_y_reg) ? y_reg - cur_y_reg : cur_y_reg - y_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        idx_next    = idx_reg;
        code_next   = code_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        t_next      = t_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        sq_next     = sq_reg;
        path_next   = path_reg;
        dist_next   = dist_reg;
        wr_en       = 1'b0;
        wr_addr     = wrap_add(eff_old, eff_cnt);
        rd_addr     = (state_reg == ST_SRCH_RD) ? wrap_add(oldest_reg, idx_reg) : oldest_reg;
        sqrt_start  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = CW'(x_position);
                    y_next    = CW'(y_position);
                    t_next    = timestamp;
                    code_next = GEST_NONE;
                    case (func)
                        FUNC_DOWN:
                        begin
                            count_next  = '0;
                            oldest_next = '0;
                            state_next  = ST_APPEND;
                        end
                        FUNC_MOTION:
                            state_next = ST_PRUNE_RD;
                        FUNC_UP:
                        begin
                            count_next  = '0;
                            oldest_next = '0;
                            state_next  = ST_OUT;
                        end
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end
            ST_PRUNE_RD:
                state_next = (count_reg == '0) ? ST_APPEND : ST_PRUNE_CHK;
            ST_PRUNE_CHK:
            begin
                if (age > {16'b0, window_reg})
                begin
                    oldest_next = wrap_add(oldest_reg, AW'(1));
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_PRUNE_RD;
                end
                else
                    state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                // A down event has just emptied the store, so it never searches.
                wr_en       = 1'b1;
                oldest_next = eff_old;
                count_next  = CNTW'(eff_cnt) + 1'b1;
                prev_x_next = x_reg;
                prev_y_next = y_reg;
                path_next   = '0;
                idx_next    = eff_cnt - 1'b1;
                state_next  = (eff_cnt == '0) ? ST_OUT : ST_SRCH_RD;
            end
            ST_SRCH_RD:
                state_next = ST_SEG_MUL;
            ST_SEG_MUL:
            begin
                cur_x_next = rd_x;
                cur_y_next = rd_y;
                sq_next    = sq_sum;
                state_next = ST_SEG_START;
            end
            ST_SEG_START:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:
            begin
                if (sqrt_done)
                begin
                    path_next  = path_reg + PW'(sqrt_root);
                    state_next = ST_DIST_MUL;
                end
            end
            ST_DIST_MUL:
            begin
                sq_next    = sq_sum;
                state_next = ST_DIST_START;
            end
            ST_DIST_START:
            begin
                sqrt_start = 1'b1;
                state_next = ST_DIST_WAIT;
            end
            ST_DIST_WAIT:
            begin
                if (sqrt_done)
                begin
                    dist_next  = sqrt_root;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (d_cmp > min_q4 && gap10 < d_cmp)
                begin
                    if (tdx > tdy)
                        code_next = (x_reg > cur_x_reg) ? GEST_RIGHT : GEST_LEFT;
                    else
                        code_next = (y_reg > cur_y_reg) ? GEST_UP : GEST_DOWN;
                    count_next  = '0;
                    oldest_next = '0;
                    state_next  = ST_OUT;
                end
                else if (idx_reg == '0)
                    state_next = ST_OUT;
                else
                begin
                    idx_next    = idx_reg - 1'b1;
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            oldest_reg <= '0;
            code_reg   <= GEST_NONE;
            window_reg <= WINDOW_RESET;
            min_reg    <= MIN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            code_reg   <= code_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW:   window_reg <= cfg_data;
                    CFG_MIN_DIST: min_reg    <= cfg_data[11:0];
                    default:      window_reg <= window_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        t_reg      <= t_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        sq_reg     <= sq_next;
        path_reg   <= path_next;
        dist_reg   <= dist_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign gesture_code = code_reg;

endmodule

// File: rtl/core/swg_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Stand-alone; used by swipe_gesture_detector.
module swg_isqrt #(
    parameter int QW = 17
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*QW-1:0] radicand,
    output logic            done,
    output logic [QW-1:0]   root
);

    localparam int CNTW = $clog2(QW + 1);

    logic [2*QW-1:0] rad_reg;
    logic [QW:0]     rem_reg;
    logic [QW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [QW+2:0] rem_sh;
    logic [QW+2:0] trial;
    logic [QW+2:0] rem_sub;
    logic          take;

    // One restoring step: bring down two radicand bits and try the next root bit.
    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[2*QW-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        take    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*QW-3:0], 2'b00};
            rem_reg  <= take ? rem_sub[QW:0] : rem_sh[QW:0];
            root_reg <= {root_reg[QW-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/swg_checker.sv
// Port-level checks for swipe_gesture_detector, attached by bind.
// Depends on swg_pkg.
module swg_checker import swg_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] func,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] gesture_code
);

    // A waiting result holds its code until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture_code))
        else $error("gesture result changed while stalled");

    // Only defined gesture codes are reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gesture_code <= GEST_DOWN)
        else $error("undefined gesture code");

    // A new request is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while a result is pending");

    // After a request is taken the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a request");

    // Down and up events never yield a gesture; up answers sooner than down, which first appends.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_DOWN || func == FUNC_UP)
        |=> ##[0:1] (out_valid && gesture_code == GEST_NONE))
        else $error("down or up event reported a gesture");

endmodule

bind swipe_gesture_detector swg_checker u_swg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gesture_code (gesture_code)
);

// File: tb/sv/swipe_gesture_detector_tb.sv
// Self-checking testbench for swipe_gesture_detector: directed table, then random gestures.
// Needs swg_pkg and the detector RTL; codes expected: checked rows, else a local predictor.
module swipe_gesture_detector_tb;
    import swg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 16;
    localparam int N_RANDOM = 1135;
    localparam int PEND_DEPTH = 4096;

    // A directed row; want_code is checked only where check_code is set.
    typedef struct {
        logic [1:0]  kind;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] ts;
        logic        check_code;
        logic [2:0]  want_code;
    } row_t;

    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] ts;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [11:0] x_position;
    logic [11:0] y_position;
    logic [31:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  gesture_code;

    swipe_gesture_detector dut (.*);

    // Predictor state.
    point_t      trail [RING];
    int unsigned trail_count;
    int unsigned trail_head;
    logic [15:0] window_ticks;
    logic [11:0] min_dist;

    // Expected codes in request order, as a ring with write and read counts.
    logic [2:0]  pending_codes [PEND_DEPTH];
    int unsigned pend_wr;
    int unsigned pend_rd;
    int          errors;
    bit          hold_off;
    row_t        table_rows[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Integer square root, bit by bit.
    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Segment length with four fraction bits.
    function automatic longint unsigned span_q4(point_t a, point_t b);
        longint dx;
        longint dy;
        dx = longint'(b.px) - longint'(a.px);
        dy = longint'(b.py) - longint'(a.py);
        return root_of((dx * dx + dy * dy) << 8);
    endfunction

    function automatic point_t trail_at(int unsigned k);
        return trail[(trail_head + k) % RING];
    endfunction

    function automatic void trail_push(point_t p);
        if (trail_count >= RING)
        begin
            trail_head = (trail_head + 1) % RING;
            trail_count = RING - 1;
        end
        trail[(trail_head + trail_count) % RING] = p;
        trail_count++;
    endfunction

    // Search back from the newest point for a straight enough long stroke.
    function automatic logic [2:0] find_swipe();
        point_t          last;
        point_t          first;
        longint unsigned d;
        longint unsigned path;
        longint unsigned gap;
        longint          dx;
        longint          dy;
        longint          ax;
        longint          ay;
        if (trail_count < 2)
            return GEST_NONE;
        last = trail_at(trail_count - 1);
        for (int i = trail_count - 1; i >= 0; i--)
        begin
            first = trail_at(i);
            d = span_q4(first, last);
            if (d > (longint'(min_dist) << 4))
            begin
                path = 0;
                for (int j = i; j + 1 < trail_count; j++)
                    path += span_q4(trail_at(j), trail_at(j + 1));
                gap = (path > d) ? path - d : d - path;
                if (gap * 10 < d)
                begin
                    dx = longint'(last.px) - longint'(first.px);
                    dy = longint'(last.py) - longint'(first.py);
                    ax = dx < 0 ? -dx : dx;
                    ay = dy < 0 ? -dy : dy;
                    if (ax > ay)
                        return dx > 0 ? GEST_RIGHT : GEST_LEFT;
                    return dy > 0 ? GEST_UP : GEST_DOWN;
                end
            end
        end
        return GEST_NONE;
    endfunction

    // Update the predictor with one request and return its gesture.
    function automatic logic [2:0] predict_gesture(logic [1:0] k, logic [11:0] px,
                                                   logic [11:0] py, logic [31:0] ts);
        logic [2:0] g;
        point_t     p;
        point_t     oldest;
        g = GEST_NONE;
        p.px = px;
        p.py = py;
        p.ts = ts;
        if (k == FUNC_DOWN)
        begin
            trail_count = 0;
            trail_head = 0;
            trail_push(p);
        end
        else if (k == FUNC_MOTION)
        begin
            while (trail_count > 0)
            begin
                oldest = trail_at(0);
                if ((ts - oldest.ts) <= 32'(window_ticks))
                    break;
                trail_head = (trail_head + 1) % RING;
                trail_count--;
            end
            trail_push(p);
            g = find_swipe();
            if (g != GEST_NONE)
            begin
                trail_count = 0;
                trail_head = 0;
            end
        end
        else if (k == FUNC_UP)
        begin
            trail_count = 0;
            trail_head = 0;
        end
        return g;
    endfunction

    // Send one request after a random gap and log its expected gesture.
    // Valid stays high after acceptance until the next request or a drain replaces it.
    task automatic send_request(logic [1:0] k, logic [11:0] px, logic [11:0] py,
                                logic [31:0] ts, bit check_code, logic [2:0] want_code);
        logic [2:0] g;
        int         gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= k;
        x_position <= px;
        y_position <= py;
        timestamp  <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        g = predict_gesture(k, px, py, ts);
        if (check_code && g !== want_code)
        begin
            $display("%0t: table row gesture: expected %0d, actual predictor %0d",
                     $time, want_code, g);
            errors++;
        end
        pending_codes[pend_wr % PEND_DEPTH] = check_code ? want_code : g;
        pend_wr++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
        // The last result was taken at this edge; the block is idle from here.
        @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_WINDOW)
            window_ticks = value;
        else
            min_dist = value[11:0];
    endtask

    // A stroke from a down event along a mostly straight random line.
    task automatic send_stroke(logic [31:0] t0, output int sent);
        int          steps;
        int          sx;
        int          sy;
        int          vx;
        int          vy;
        int          cx;
        int          cy;
        logic [31:0] ts;
        sent = 0;
        steps = $urandom_range(2, 20);
        sx = $urandom_range(0, 4095);
        sy = $urandom_range(0, 4095);
        vx = int'($urandom_range(0, 80)) - 40;
        vy = int'($urandom_range(0, 80)) - 40;
        ts = t0;
        send_request(FUNC_DOWN, 12'(sx), 12'(sy), ts, 1'b0, GEST_NONE);
        sent++;
        for (int s = 1; s <= steps; s++)
        begin
            cx = sx + vx * s + int'($urandom_range(0, 6)) - 3;
            cy = sy + vy * s + int'($urandom_range(0, 6)) - 3;
            cx = cx < 0 ? 0 : (cx > 4095 ? 4095 : cx);
            cy = cy < 0 ? 0 : (cy > 4095 ? 4095 : cy);
            ts += $urandom_range(0, 60);
            send_request(FUNC_MOTION, 12'(cx), 12'(cy), ts, 1'b0, GEST_NONE);
            sent++;
        end
        if ($urandom_range(0, 1))
        begin
            send_request(FUNC_UP, 12'(cx), 12'(cy), ts, 1'b0, GEST_NONE);
            sent++;
        end
    endtask

    // Result checker with random stalls and one long hold-off.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold_off)
                stall = 3000;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pend_wr == pend_rd)
            begin
                $display("%0t: unexpected gesture: expected none, actual %0d",
                         $time, gesture_code);
                errors++;
            end
            else
            begin
                logic [2:0] want;
                want = pending_codes[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (gesture_code !== want)
                begin
                    $display("%0t: gesture_code mismatch: expected %0d, actual %0d",
                             $time, want, gesture_code);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        #400ms;
        $display("swipe_gesture_detector_tb: FAIL");
        $finish;
    end

    // Stimulus.
    initial
    begin
        logic [31:0] ts;
        int          phase;
        int          sent;
        errors       = 0;
        hold_off     = 1'b0;
        pend_wr      = 0;
        pend_rd      = 0;
        trail_count  = 0;
        trail_head   = 0;
        window_ticks = WINDOW_RESET;
        min_dist     = MIN_RESET;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_WINDOW;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_UP;
        x_position   = '0;
        y_position   = '0;
        timestamp    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, each event kind, ties, full ring, wrapped time.
        table_rows = '{
            '{FUNC_MOTION, 12'd0,    12'd0,    32'd0,          1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd4095, 12'd0,    32'd10,         1'b1, GEST_RIGHT},
            '{FUNC_DOWN,   12'd4095, 12'd4095, 32'd20,         1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd0,    12'd4095, 32'd30,         1'b1, GEST_LEFT},
            '{FUNC_DOWN,   12'd100,  12'd100,  32'd40,         1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd200,  12'd200,  32'd50,         1'b1, GEST_UP},
            '{FUNC_DOWN,   12'd500,  12'd4095, 32'd60,         1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd500,  12'd0,    32'd70,         1'b1, GEST_DOWN},
            '{FUNC_DOWN,   12'd0,    12'd0,    32'd80,         1'b1, GEST_NONE},
            '{FUNC_UP,     12'd4095, 12'd4095, 32'd90,         1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd4095, 12'd4095, 32'd100,        1'b1, GEST_NONE},
            '{2'd3,        12'd0,    12'd0,    32'hFFFF_FFFF,  1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd0,    12'd0,    32'd90,         1'b1, GEST_NONE},
            '{FUNC_DOWN,   12'd10,   12'd10,   32'hFFFF_FFF0,  1'b1, GEST_NONE},
            '{FUNC_MOTION, 12'd11,   12'd10,   32'd5,          1'b0, GEST_NONE},
            '{FUNC_MOTION, 12'd3000, 12'd10,   32'd6,          1'b0, GEST_NONE},
            '{FUNC_DOWN,   12'd2048, 12'd2048, 32'd1000,       1'b1, GEST_NONE}
        };
        for (int r = 0; r < table_rows.size(); r++)
            send_request(table_rows[r].kind, table_rows[r].px, table_rows[r].py,
                         table_rows[r].ts, table_rows[r].check_code, table_rows[r].want_code);
        // Eighteen small steps overflow the ring.
        for (int s = 1; s <= 18; s++)
            send_request(FUNC_MOTION, 12'(2048 + s), 12'd2048, 32'(1000 + s), 1'b0, GEST_NONE);
        wait_drained();

        // Random part over several register settings; each phase ends drained.
        ts = 32'd5000;
        phase = 0;
        for (int n = 0; n < N_RANDOM; )
        begin
            if (n >= phase * 120)
            begin
                wait_drained();
                case (phase % 5)
                    0: begin write_register(CFG_WINDOW, 16'd1);
                             write_register(CFG_MIN_DIST, 16'd0); end
                    1: begin write_register(CFG_WINDOW, 16'd65535);
                             write_register(CFG_MIN_DIST, 16'd4095); end
                    2: begin write_register(CFG_WINDOW, 16'(300 + $urandom_range(0, 700)));
                             write_register(CFG_MIN_DIST, 16'($urandom_range(0, 120))); end
                    3: begin write_register(CFG_WINDOW, 16'd0);
                             write_register(CFG_MIN_DIST, 16'd10); end
                    default: begin write_register(CFG_WINDOW, WINDOW_RESET);
                                   write_register(CFG_MIN_DIST, MIN_RESET); end
                endcase
                cfg_we <= 1'b0;
                phase++;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_stroke(ts, sent);
                n += sent;
            end
            else
            begin
                send_request(2'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                             ($urandom_range(0, 7) == 0) ? $urandom : ts, 1'b0, GEST_NONE);
                n++;
            end
            ts += $urandom_range(0, 400);
            if (n >= 600 && n < 621)
            begin
                // The checker stops taking results while requests keep coming.
                hold_off = 1'b1;
                send_stroke(ts, sent);
                hold_off = 1'b0;
                n += (sent > 21) ? sent : 21;
            end
        end

        wait_drained();
        if (errors == 0)
            $display("swipe_gesture_detector_tb: PASS");
        else
            $display("swipe_gesture_detector_tb: FAIL");
        $finish;
    end

endmodule
